FILE: rtl/core/global_average_pool_top_macros.svh
// Assertion macros shared by the pooling block.
`ifndef GLOBAL_AVERAGE_POOL_TOP_MACROS_SVH
`define GLOBAL_AVERAGE_POOL_TOP_MACROS_SVH

// Condition must never hold while out of reset.
`define GAP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("gap assertion failed");

// Antecedent implies consequent in the same cycle.
`define GAP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gap assertion failed");

`endif

FILE: rtl/core/gap_pkg.sv
package gap_pkg;

  // Configuration register widths.
  localparam int WIN_W      = 13;
  localparam int CHN_W      = 11;
  localparam int WIN_CMP_W  = WIN_W + 1;
  localparam int CHN_CMP_W  = CHN_W + 1;
  localparam int WIN_MAX    = (1 << WIN_W) - 1;
  localparam int CHN_MAX    = (1 << CHN_W) - 1;
  localparam int WIN_RESET  = 49;
  localparam int CHN_RESET  = 1;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = WIN_W;

  // Result tag widths.
  localparam int CHAN_OUT_W = 10;
  localparam int POS_OUT_W  = 12;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PASS_MODE     = 2'd0,
    REG_WINDOW_SIZE   = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    PASS_FWD = 1'b0,
    PASS_BWD = 1'b1
  } pass_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN,
    BK_HOLD
  } back_state_e;

  // Tag that travels with each division job.
  typedef struct packed {
    pass_e                 mode;
    logic                  last;
    logic [CHAN_OUT_W-1:0] channel;
    logic [POS_OUT_W-1:0]  position;
  } job_meta_t;

endpackage

FILE: rtl/core/global_average_pool_top.sv
// Global average pooling over a channel-major stream of Q16.16 samples.
// Input channel: push_i/full_o; an item (sample_value_i, prior_gradient_i)
// is taken on a clock edge with push_i high and full_o low. Result channel:
// empty_o/pop_i; the oldest result sits on the result ports while empty_o is
// low and leaves on an edge with pop_i high.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 pass mode, 1 window size, 2 channel count) and restarts the image; a
// write to index 3 changes nothing. The front takes one item per cycle while
// full_o is low, keeps the running channel sum and the position/channel
// counters, and queues one division job per result. The back is a radix-2
// restoring divider, one quotient bit per cycle over the SUM_W-bit dividend
// (45 bits with the default sizes). It takes one job at a time: it loads the
// job, divides, registers the result and holds it on the ports until it is
// popped. Forward mode takes one item per cycle while the job queue has room
// for each item that closes a window; backward mode makes one result per
// item, so the divider sets the rate.
// Reset restores pass mode 0, window 49, one channel and clears all progress.
// A stalled receiver holds the result; the job queue then fills and full_o
// rises only for items that would need a job.
module global_average_pool_top #(
  parameter int MAX_WINDOW   = 4096,
  parameter int MAX_CHANNELS = 1024,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gap_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [gap_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [DATA_WIDTH-1:0]     sample_value_i,
  input  logic signed [DATA_WIDTH-1:0]     prior_gradient_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic signed [DATA_WIDTH-1:0]     result_value_o,
  output logic [gap_pkg::CHAN_OUT_W-1:0]   channel_index_o,
  output logic [gap_pkg::POS_OUT_W-1:0]    position_index_o,
  output logic                             last_of_image_o
);

  // Largest window the register can select, and the sum width it needs.
  localparam int WMAX   = (MAX_WINDOW < gap_pkg::WIN_MAX) ? MAX_WINDOW : gap_pkg::WIN_MAX;
  localparam int SUM_W  = DATA_WIDTH + $clog2(WMAX + 1);
  localparam int META_W = $bits(gap_pkg::job_meta_t);
  localparam int JOB_W  = META_W + SUM_W + DATA_WIDTH + gap_pkg::WIN_W;

  gap_pkg::job_meta_t              fr_meta, bk_meta;
  logic signed [SUM_W-1:0]         fr_dividend, bk_dividend;
  logic signed [DATA_WIDTH-1:0]    fr_prior, bk_prior;
  logic [gap_pkg::WIN_W-1:0]       fr_divisor, bk_divisor;
  logic                            job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0]                job_wdata, job_rdata;

  gap_front #(
    .DATA_WIDTH  (DATA_WIDTH),
    .SUM_W       (SUM_W),
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push_i          (push_i),
    .sample_value_i  (sample_value_i),
    .prior_gradient_i(prior_gradient_i),
    .full_o          (full_o),
    .job_push_o      (job_push),
    .job_full_i      (job_full),
    .job_meta_o      (fr_meta),
    .job_dividend_o  (fr_dividend),
    .job_prior_o     (fr_prior),
    .job_divisor_o   (fr_divisor)
  );

  // Pack the job word: tag, dividend, prior gradient, divisor.
  assign job_wdata = {fr_meta, fr_dividend, fr_prior, fr_divisor};

  gap_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_wdata),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .empty_o(job_empty)
  );

  assign bk_meta     = job_rdata[JOB_W-1 -: META_W];
  assign bk_dividend = job_rdata[SUM_W + DATA_WIDTH + gap_pkg::WIN_W - 1 -: SUM_W];
  assign bk_prior    = job_rdata[DATA_WIDTH + gap_pkg::WIN_W - 1 -: DATA_WIDTH];
  assign bk_divisor  = job_rdata[gap_pkg::WIN_W-1:0];

  gap_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .SUM_W     (SUM_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_empty_i     (job_empty),
    .job_pop_o       (job_pop),
    .job_meta_i      (bk_meta),
    .job_dividend_i  (bk_dividend),
    .job_prior_i     (bk_prior),
    .job_divisor_i   (bk_divisor),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .result_value_o  (result_value_o),
    .channel_index_o (channel_index_o),
    .position_index_o(position_index_o),
    .last_of_image_o (last_of_image_o)
  );

endmodule

FILE: rtl/core/gap_fifo.sv
module gap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

`include "global_average_pool_top_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `GAP_ASSERT_NEVER(no_push_when_full, clk_i, rst_ni, push_i && full_o)
  `GAP_ASSERT_NEVER(no_pop_when_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

FILE: rtl/core/gap_front.sv
module gap_front #(
  parameter int DATA_WIDTH   = 32,
  parameter int SUM_W        = 45,
  parameter int MAX_WINDOW   = 4096,
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gap_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [gap_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             push_i,
  input  logic signed [DATA_WIDTH-1:0]     sample_value_i,
  input  logic signed [DATA_WIDTH-1:0]     prior_gradient_i,
  output logic                             full_o,
  output logic                             job_push_o,
  input  logic                             job_full_i,
  output gap_pkg::job_meta_t               job_meta_o,
  output logic signed [SUM_W-1:0]          job_dividend_o,
  output logic signed [DATA_WIDTH-1:0]     job_prior_o,
  output logic [gap_pkg::WIN_W-1:0]        job_divisor_o
);

`include "global_average_pool_top_macros.svh"

  localparam int WMAX    = (MAX_WINDOW < gap_pkg::WIN_MAX) ? MAX_WINDOW : gap_pkg::WIN_MAX;
  localparam int CMAX    = (MAX_CHANNELS < gap_pkg::CHN_MAX) ? MAX_CHANNELS : gap_pkg::CHN_MAX;
  localparam int PW      = (WMAX > 1) ? $clog2(WMAX) : 1;
  localparam int CW      = (CMAX > 1) ? $clog2(CMAX) : 1;
  localparam int WIN_RST = (gap_pkg::WIN_RESET > WMAX) ? WMAX : gap_pkg::WIN_RESET;
  localparam int CHN_RST = (gap_pkg::CHN_RESET > CMAX) ? CMAX : gap_pkg::CHN_RESET;

  function automatic logic [gap_pkg::WIN_W-1:0] clamp_win(input logic [gap_pkg::WIN_W-1:0] raw);
    if (raw == '0) return gap_pkg::WIN_W'(1);
    if (int'(raw) > WMAX) return gap_pkg::WIN_W'(WMAX);
    return raw;
  endfunction

  function automatic logic [gap_pkg::CHN_W-1:0] clamp_chn(input logic [gap_pkg::CHN_W-1:0] raw);
    if (raw == '0) return gap_pkg::CHN_W'(1);
    if (int'(raw) > CMAX) return gap_pkg::CHN_W'(CMAX);
    return raw;
  endfunction

  gap_pkg::pass_e             mode_q, mode_d;
  logic [gap_pkg::WIN_W-1:0]  win_q, win_d;
  logic [gap_pkg::CHN_W-1:0]  chn_q, chn_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [CW-1:0]              chan_q, chan_d;

  logic                       last_pos, last_chan, needs_slot, accept;
  logic signed [SUM_W-1:0]    sample_ext, sum_acc;

  assign last_pos   = (gap_pkg::WIN_CMP_W'(pos_q) + gap_pkg::WIN_CMP_W'(1))
                      >= gap_pkg::WIN_CMP_W'(win_q);
  assign last_chan  = (gap_pkg::CHN_CMP_W'(chan_q) + gap_pkg::CHN_CMP_W'(1))
                      >= gap_pkg::CHN_CMP_W'(chn_q);
  // Forward items that close no window never need a job slot.
  assign needs_slot = (mode_q == gap_pkg::PASS_BWD) || last_pos;
  assign full_o     = job_full_i && needs_slot;
  assign accept     = push_i && !full_o;
  assign sample_ext = SUM_W'(sample_value_i);
  assign sum_acc    = sum_q + sample_ext;

  assign job_push_o          = accept && needs_slot;
  assign job_dividend_o      = (mode_q == gap_pkg::PASS_FWD) ? sum_acc : sample_ext;
  assign job_prior_o         = prior_gradient_i;
  assign job_divisor_o       = win_q;
  assign job_meta_o.mode     = mode_q;
  assign job_meta_o.last     = last_pos && last_chan;
  assign job_meta_o.channel  = gap_pkg::CHAN_OUT_W'(chan_q);
  assign job_meta_o.position = (mode_q == gap_pkg::PASS_FWD) ? '0
                               : gap_pkg::POS_OUT_W'(pos_q);

  always_comb begin
    mode_d = mode_q;
    win_d  = win_q;
    chn_d  = chn_q;
    sum_d  = sum_q;
    pos_d  = pos_q;
    chan_d = chan_q;
    if (cfg_we_i) begin
      case (gap_pkg::cfg_reg_e'(cfg_addr_i))
        gap_pkg::REG_PASS_MODE: begin
          mode_d = gap_pkg::pass_e'(cfg_wdata_i[0]);
          sum_d  = '0;
          pos_d  = '0;
          chan_d = '0;
        end
        gap_pkg::REG_WINDOW_SIZE: begin
          win_d  = clamp_win(cfg_wdata_i);
          sum_d  = '0;
          pos_d  = '0;
          chan_d = '0;
        end
        gap_pkg::REG_CHANNEL_COUNT: begin
          chn_d  = clamp_chn(cfg_wdata_i[gap_pkg::CHN_W-1:0]);
          sum_d  = '0;
          pos_d  = '0;
          chan_d = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (mode_q == gap_pkg::PASS_FWD) begin
        sum_d = last_pos ? '0 : sum_acc;
      end
      if (last_pos) begin
        pos_d  = '0;
        chan_d = last_chan ? '0 : chan_q + CW'(1);
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gap_pkg::PASS_FWD;
      win_q  <= gap_pkg::WIN_W'(WIN_RST);
      chn_q  <= gap_pkg::CHN_W'(CHN_RST);
      sum_q  <= '0;
      pos_q  <= '0;
      chan_q <= '0;
    end else begin
      mode_q <= mode_d;
      win_q  <= win_d;
      chn_q  <= chn_d;
      sum_q  <= sum_d;
      pos_q  <= pos_d;
      chan_q <= chan_d;
    end
  end

  `GAP_ASSERT_NEVER(pos_inside_window, clk_i, rst_ni, gap_pkg::WIN_CMP_W'(pos_q) >= gap_pkg::WIN_CMP_W'(win_q))

endmodule

FILE: rtl/core/gap_back.sv
module gap_back #(
  parameter int DATA_WIDTH = 32,
  parameter int SUM_W      = 45
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_empty_i,
  output logic                              job_pop_o,
  input  gap_pkg::job_meta_t                job_meta_i,
  input  logic signed [SUM_W-1:0]           job_dividend_i,
  input  logic signed [DATA_WIDTH-1:0]      job_prior_i,
  input  logic [gap_pkg::WIN_W-1:0]         job_divisor_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [DATA_WIDTH-1:0]      result_value_o,
  output logic [gap_pkg::CHAN_OUT_W-1:0]    channel_index_o,
  output logic [gap_pkg::POS_OUT_W-1:0]     position_index_o,
  output logic                              last_of_image_o
);

`include "global_average_pool_top_macros.svh"

  localparam int CNT_W = $clog2(SUM_W + 1);

  gap_pkg::back_state_e              state_q, state_d;
  gap_pkg::job_meta_t                meta_q;
  logic                              neg_q;
  logic [SUM_W-1:0]                  quo_q;
  logic [gap_pkg::WIN_W-1:0]         rem_q;
  logic [gap_pkg::WIN_W-1:0]         dvs_q;
  logic signed [DATA_WIDTH-1:0]      prior_q;
  logic [CNT_W-1:0]                  step_q;
  logic signed [DATA_WIDTH-1:0]      res_q;

  logic                              load, step, finish;
  logic [gap_pkg::WIN_W:0]           rem_sh, diff;
  logic                              ge;
  logic [SUM_W-1:0]                  mag;
  logic signed [SUM_W-1:0]           quo_s;
  logic signed [DATA_WIDTH:0]        upd;
  logic signed [DATA_WIDTH-1:0]      res_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gap_pkg::BK_IDLE: if (!job_empty_i) state_d = gap_pkg::BK_DIV;
      gap_pkg::BK_DIV:  if (step_q == CNT_W'(1)) state_d = gap_pkg::BK_FIN;
      gap_pkg::BK_FIN:  state_d = gap_pkg::BK_HOLD;
      gap_pkg::BK_HOLD: if (pop_i) state_d = gap_pkg::BK_IDLE;
      default:          state_d = gap_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load    = 1'b0;
    step    = 1'b0;
    finish  = 1'b0;
    empty_o = 1'b1;
    case (state_q)
      gap_pkg::BK_IDLE: load = !job_empty_i;
      gap_pkg::BK_DIV:  step = 1'b1;
      gap_pkg::BK_FIN:  finish = 1'b1;
      gap_pkg::BK_HOLD: empty_o = 1'b0;
      default: begin
      end
    endcase
  end

  assign job_pop_o = load;

  // One restoring step of the unsigned magnitude division.
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[gap_pkg::WIN_W];
  assign mag    = job_dividend_i[SUM_W-1] ? SUM_W'(-job_dividend_i) : SUM_W'(job_dividend_i);

  // Apply sign, then either truncate the mean or add and saturate the gradient.
  always_comb begin
    quo_s = neg_q ? -$signed(quo_q) : $signed(quo_q);
    upd   = (DATA_WIDTH + 1)'(prior_q) + $signed(quo_s[DATA_WIDTH:0]);
    if (meta_q.mode == gap_pkg::PASS_FWD) begin
      res_d = quo_s[DATA_WIDTH-1:0];
    end else if (upd[DATA_WIDTH] != upd[DATA_WIDTH-1]) begin
      res_d = upd[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      res_d = upd[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gap_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= CNT_W'(SUM_W);
      end else if (step) begin
        step_q <= step_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      meta_q  <= job_meta_i;
      neg_q   <= job_dividend_i[SUM_W-1];
      quo_q   <= mag;
      rem_q   <= '0;
      dvs_q   <= job_divisor_i;
      prior_q <= job_prior_i;
    end else if (step) begin
      rem_q <= ge ? diff[gap_pkg::WIN_W-1:0] : rem_sh[gap_pkg::WIN_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign result_value_o   = res_q;
  assign channel_index_o  = meta_q.channel;
  assign position_index_o = meta_q.position;
  assign last_of_image_o  = meta_q.last;

  `GAP_ASSERT_IMPLIES(fin_follows_div, clk_i, rst_ni, state_q == gap_pkg::BK_FIN, $past(state_q) == gap_pkg::BK_DIV)
  `GAP_ASSERT_IMPLIES(div_has_steps, clk_i, rst_ni, state_q == gap_pkg::BK_DIV, step_q != '0)

endmodule

FILE: bench/global_average_pool_top_test.sv
module global_average_pool_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gap_pkg::*;

  localparam int DW             = 32;
  localparam int WINDOW_CAP     = 4096;
  localparam int CHANNEL_CAP    = 1024;
  localparam int RANDOM_ITEMS   = 420;
  localparam int RANDOM_RESULTS = 48;
  // Long enough for a divider job to finish with default sizes, with margin.
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_CAP     = 40;

  localparam longint DATA_HI = 64'sd2147483647;
  localparam longint DATA_LO = -64'sd2147483648;

  typedef logic signed [DW-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

  // Index past the end of the register map; the block must ignore it.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = '1;

  typedef struct packed {
    sample_t               value;
    logic [CHAN_OUT_W-1:0] chan;
    logic [POS_OUT_W-1:0]  pos;
    logic                  last;
  } pool_result_t;

  // Predicts pooled results from accepted items and checks them in order.
  class pool_scoreboard;
    pass_e        mode;
    int           window_reg;
    int           channel_reg;
    longint       channel_sum;
    int           position;
    int           channel;
    pool_result_t awaited_q[$];
    int           accepted;
    int           produced;
    int           checked;
    int           errors;

    function new();
      mode        = PASS_FWD;
      window_reg  = WIN_RESET;
      channel_reg = CHN_RESET;
      accepted    = 0;
      produced    = 0;
      checked     = 0;
      errors      = 0;
      clear_progress();
    endfunction

    function void clear_progress();
      channel_sum = 0;
      position    = 0;
      channel     = 0;
    endfunction

    function int eff_window();
      if (window_reg == 0) return 1;
      if (window_reg > WINDOW_CAP) return WINDOW_CAP;
      return window_reg;
    endfunction

    function int eff_channels();
      if (channel_reg == 0) return 1;
      if (channel_reg > CHANNEL_CAP) return CHANNEL_CAP;
      return channel_reg;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // Any listed register restarts the image; unknown indexes change nothing.
    function void apply_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PASS_MODE:     mode = pass_e'(d[0]);
        REG_WINDOW_SIZE:   window_reg = int'(d);
        REG_CHANNEL_COUNT: channel_reg = int'(d[CHN_W-1:0]);
        default:           return;
      endcase
      clear_progress();
    endfunction

    function void take_sample(sample_t s, sample_t p);
      longint       win;
      longint       upd;
      bit           last_pos;
      bit           last_chan;
      pool_result_t r;
      accepted++;
      win       = eff_window();
      last_pos  = (position + 1 >= win);
      last_chan = (channel + 1 >= eff_channels());
      r.chan    = CHAN_OUT_W'(channel);
      r.pos     = '0;
      r.last    = last_chan;
      if (mode == PASS_FWD) begin
        channel_sum += longint'(s);
        if (last_pos) begin
          // Mean truncates toward zero, like the signed divide here.
          upd     = channel_sum / win;
          r.value = upd[DW-1:0];
          awaited_q.push_back(r);
          produced++;
          channel_sum = 0;
        end
      end else begin
        upd = longint'(p) + longint'(s) / win;
        if (upd > DATA_HI) upd = DATA_HI;
        if (upd < DATA_LO) upd = DATA_LO;
        r.value = upd[DW-1:0];
        r.pos   = POS_OUT_W'(position);
        r.last  = last_pos && last_chan;
        awaited_q.push_back(r);
        produced++;
      end
      if (last_pos) begin
        position = 0;
        channel  = last_chan ? 0 : channel + 1;
      end else begin
        position++;
      end
    endfunction

    function void report(string what, logic signed [63:0] want, logic signed [63:0] got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s, expected %0d, actual %0d", $time, what, want, got);
      else if (errors == REPORT_CAP + 1)
        $display("%0t: further mismatches counted but not shown", $time);
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) report({field, " mismatch"}, want, got);
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (awaited_q.size() == 0) begin
        report("result with nothing awaited (expected none)", '0, got.value);
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      compare("result_value", want.value, got.value);
      compare("channel_index", want.chan, got.chan);
      compare("position_index", want.pos, got.pos);
      compare("last_of_image", want.last, got.last);
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i      = '0;
  logic                  push_i           = 1'b0;
  sample_t               sample_value_i   = '0;
  sample_t               prior_gradient_i = '0;
  logic                  pop_i            = 1'b0;
  logic                  full_o;
  logic                  empty_o;
  sample_t               result_value_o;
  logic [CHAN_OUT_W-1:0] channel_index_o;
  logic [POS_OUT_W-1:0]  position_index_o;
  logic                  last_of_image_o;

  pool_scoreboard board;
  int             phases      = 0;
  int             burst_left  = 0;
  bit             gaps_on     = 1'b0;
  int             idle_cycles = 0;

  global_average_pool_top #(
    .MAX_WINDOW   (WINDOW_CAP),
    .MAX_CHANNELS (CHANNEL_CAP),
    .DATA_WIDTH   (DW)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .sample_value_i   (sample_value_i),
    .prior_gradient_i (prior_gradient_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .result_value_o   (result_value_o),
    .channel_index_o  (channel_index_o),
    .position_index_o (position_index_o),
    .last_of_image_o  (last_of_image_o)
  );

  // 10 ns period: low half, then high half.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bias values toward the extremes so sums saturate and wide sums get exercised.
  function automatic sample_t pick_data();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return sample_t'($urandom_range(0, 4000)) - sample_t'(2000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Drive one item and hold it until the block takes it. Enter and leave on a
  // falling edge; push_i stays high so a following item goes back to back.
  task automatic send_item(input sample_t s, input sample_t p);
    push_i           <= 1'b1;
    sample_value_i   <= s;
    prior_gradient_i <= p;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    board.take_sample(s, p);
    @(negedge clk_i);
  endtask

  // Sender pacing: bursts of random length, random gaps in between.
  task automatic pace();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Drop push and hold off until every awaited result is out, then let the
  // divider run dry so a forward item without a result cannot still be busy.
  task automatic wait_for_results();
    push_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    board.apply_write(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reprogram all three registers once the block is idle. Upper bits of the
  // mode word are random; only bit 0 counts.
  task automatic configure_pool(input pass_e m, input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] c);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = m;
    wait_for_results();
    write_register(REG_PASS_MODE, mode_word);
    write_register(REG_WINDOW_SIZE, w);
    write_register(REG_CHANNEL_COUNT, c);
    if ($urandom_range(0, 3) == 0) write_register(REG_SPARE, CFG_DATA_W'($urandom));
    phases++;
  endtask

  // Receiver: pop on a randomly chosen pattern, picked anew after each stretch:
  // free running, coin flip, long stalls, or sparse pops. Check each item taken.
  initial begin : result_sink
    int           style;
    int           style_left;
    int           stall_left;
    pool_result_t got;
    style      = 0;
    style_left = 0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(50, 400);
      end
      style_left--;
      case (style)
        0: pop_i <= 1'b1;
        1: pop_i <= ($urandom_range(0, 1) == 1);
        2: begin
          if (stall_left == 0) stall_left = $urandom_range(1, 80);
          stall_left--;
          pop_i <= (stall_left == 0);
        end
        default: pop_i <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        got.value = result_value_o;
        got.chan  = channel_index_o;
        got.pos   = position_index_o;
        got.last  = last_of_image_o;
        board.check_result(got);
      end
    end
  end

  // Watchdog: end the run if no item, result or register write moves for
  // too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int    n;
    int    img;
    int    pause_at;
    int    rand_items;
    int    rand_base;
    pass_e m;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] c;

    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: forward, window 49, one channel. One full window of the
    // most negative value must average to itself.
    for (int k = 0; k < 49; k++) send_item(SAMPLE_MIN, pick_data());

    // Forward extremes and truncation toward zero on a negative sum.
    configure_pool(PASS_FWD, 13'd2, 13'd2);
    send_item(SAMPLE_MAX, '0);
    send_item(SAMPLE_MAX, '0);
    send_item(SAMPLE_MIN, '0);
    send_item(SAMPLE_MIN, '0);
    send_item(32'sd1, '0);
    send_item(-32'sd2, '0);
    send_item(32'sd3, '0);
    send_item(32'sd0, '0);

    // Write to an index past the map mid-channel: the partial sum must survive.
    send_item(32'sd5, '0);
    wait_for_results();
    write_register(REG_SPARE, CFG_DATA_W'($urandom));
    send_item(32'sd6, '0);
    // Rewriting a listed register mid-channel drops the partial sum.
    send_item(32'sd100, '0);
    wait_for_results();
    write_register(REG_CHANNEL_COUNT, 13'd2);
    send_item(32'sd4, '0);
    send_item(32'sd4, '0);

    // Zero window and zero channel count both behave as one.
    configure_pool(PASS_FWD, 13'd0, 13'd0);
    send_item(-32'sd5, SAMPLE_MAX);

    // Backward: saturation at both ends, then truncated spreading.
    configure_pool(PASS_BWD, 13'd1, 13'd2);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    wait_for_results();
    write_register(REG_WINDOW_SIZE, 13'd3);
    send_item(-32'sd7, 32'sd0);
    send_item(32'sd7, 32'sd10);
    send_item(32'sd1, SAMPLE_MIN);

    // Largest window, written past the cap: gradients spread over 4096.
    configure_pool(PASS_BWD, 13'h1FFF, 13'd1);
    for (int k = 0; k < 24; k++) send_item(pick_data(), pick_data());

    // Window exactly at the cap, channel count past it, backward.
    configure_pool(PASS_BWD, 13'd4096, 13'h07FF);
    for (int k = 0; k < 40; k++) send_item(pick_data(), pick_data());

    // Channel count at the cap: one result per item, channel index steps by one.
    configure_pool(PASS_FWD, 13'd1, 13'd1024);
    for (int k = 0; k < 40; k++) send_item(pick_data(), pick_data());

    // Random phases: mostly whole images with small sizes, sometimes a ragged
    // tail that the next register write cuts off, sometimes odd sizes.
    rand_items = 0;
    rand_base  = board.produced;
    while (rand_items < RANDOM_ITEMS || board.produced - rand_base < RANDOM_RESULTS) begin
      m = pass_e'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = CFG_DATA_W'($urandom);
        2, 3:    w = CFG_DATA_W'($urandom_range(9, 64));
        default: w = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       c = '0;
        1:       c = CFG_DATA_W'($urandom);
        2:       c = CFG_DATA_W'($urandom_range(5, 16));
        default: c = CFG_DATA_W'($urandom_range(1, 4));
      endcase
      configure_pool(m, w, c);
      img = board.eff_window() * board.eff_channels();
      if (m == PASS_FWD && img <= 96) n = img * $urandom_range(1, 3);
      else n = $urandom_range(4, 40);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 7);
      pause_at   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 2) : -1;
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(0, 24);
      for (int k = 0; k < n; k++) begin
        send_item(pick_data(), pick_data());
        rand_items++;
        // Hold off the sender at a random point until every result is out.
        if (k == n - 1) ;
        else if (k == pause_at) wait_for_results();
        else pace();
      end
    end

    wait_for_results();
    $display("Run covered %0d items over %0d register settings, %0d results checked.",
             board.accepted, phases, board.checked);
    $display("Both modes ran, with windows 1 to 4096 and channel counts 1 to 1024.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
